// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the RTL: clocked implication checks that are
// disabled while reset is active.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when a holds, c must hold on the same edge.
`define ASSERT_IMPLIES(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("implication check failed");

// Next-cycle implication: when a holds, c must hold on the following edge.
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("next-cycle check failed");

`endif

// ----- rtl/skt_pkg.sv -----
// ----------------------------------------------------------------------------
// skt_pkg
// Shared field widths, codes and controller/datapath interface types for the
// sorted key table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package skt_pkg;

  // Transaction field widths
  localparam int KEY_W    = 64;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 6;
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 7;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_FOUND     = 3'd0,
    STAT_INSERTED  = 3'd1,
    STAT_NOT_FOUND = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_BAD_INDEX = 3'd4
  } status_e;

  // Which result the datapath latches
  typedef enum logic [2:0] {
    RES_FOUND_MEM,
    RES_READ_IDX,
    RES_NOT_FOUND,
    RES_FULL,
    RES_BAD,
    RES_INSERTED
  } res_sel_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SEARCH,
    ST_PROBE,
    ST_IDX_WAIT,
    ST_SHIFT,
    ST_WRITE,
    ST_RESULT
  } state_e;

  // Controller -> datapath
  typedef struct packed {
    logic     load;       // capture input transaction
    logic     probe_rd;   // read midpoint of search window
    logic     probe_lt;   // key below probe: shrink window from above
    logic     probe_gt;   // key above probe: shrink window from below
    logic     idx_rd;     // read entry at requested index
    logic     shift_rd;   // read next entry to move up
    logic     shift_wr;   // write moved entry one place up
    logic     write_new;  // store new pair, bump count
    logic     res_load;   // latch result
    res_sel_e res_sel;
    logic     out_load;   // move result into output register
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic is_insert;
    logic is_lookup;
    logic is_read;
    logic idx_ok;       // index below entry count
    logic open;         // search window not empty
    logic key_eq;       // key equals probed entry
    logic key_lt;       // key below probed entry
    logic full;
    logic shift_more;   // entries left to move
    logic shift_pend;   // a moved entry waits to be written
  } stat_t;

endpackage

// ----- rtl/skt_ram.sv -----
// ----------------------------------------------------------------------------
// skt_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module skt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/skt_ctrl.sv -----
// ----------------------------------------------------------------------------
// skt_ctrl
// Sequencer for the sorted key table: accepts one transaction, steps the
// binary search, the shift-up pass and the result handoff.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module skt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  output logic          s_ready_o,
  input  logic          m_ready_i,
  output logic          m_valid_o,
  input  skt_pkg::stat_t st_i,
  output skt_pkg::cmd_t  cmd_o
);

  import skt_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (st_i.is_read) begin
          state_d = st_i.idx_ok ? ST_IDX_WAIT : ST_RESULT;
        end else if (st_i.is_insert || st_i.is_lookup) begin
          state_d = ST_SEARCH;
        end else begin
          state_d = ST_RESULT;
        end
      end
      ST_SEARCH: begin
        if (st_i.open) begin
          state_d = ST_PROBE;
        end else if (st_i.is_lookup || st_i.full) begin
          state_d = ST_RESULT;
        end else begin
          state_d = ST_SHIFT;
        end
      end
      ST_PROBE: begin
        state_d = st_i.key_eq ? ST_RESULT : ST_SEARCH;
      end
      ST_IDX_WAIT: state_d = ST_RESULT;
      ST_SHIFT: begin
        if (!st_i.shift_more && !st_i.shift_pend) state_d = ST_WRITE;
      end
      ST_WRITE: state_d = ST_RESULT;
      ST_RESULT: begin
        if (!out_valid_q || m_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o     = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o  = 1'b1;
        cmd_o.load = s_valid_i;
      end
      ST_DISPATCH: begin
        if (st_i.is_read && st_i.idx_ok) begin
          cmd_o.idx_rd = 1'b1;
        end else if (!(st_i.is_insert || st_i.is_lookup)) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_BAD;
        end
      end
      ST_SEARCH: begin
        if (st_i.open) begin
          cmd_o.probe_rd = 1'b1;
        end else if (st_i.is_lookup) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_NOT_FOUND;
        end else if (st_i.full) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_FULL;
        end
      end
      ST_PROBE: begin
        if (st_i.key_eq) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_FOUND_MEM;
        end else if (st_i.key_lt) begin
          cmd_o.probe_lt = 1'b1;
        end else begin
          cmd_o.probe_gt = 1'b1;
        end
      end
      ST_IDX_WAIT: begin
        cmd_o.res_load = 1'b1;
        cmd_o.res_sel  = RES_READ_IDX;
      end
      ST_SHIFT: begin
        cmd_o.shift_rd = st_i.shift_more;
        cmd_o.shift_wr = st_i.shift_pend;
      end
      ST_WRITE: begin
        cmd_o.write_new = 1'b1;
        cmd_o.res_load  = 1'b1;
        cmd_o.res_sel   = RES_INSERTED;
      end
      ST_RESULT: begin
        cmd_o.out_load = !out_valid_q || m_ready_i;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // Output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_valid_o = out_valid_q;

endmodule

// ----- rtl/skt_datapath.sv -----
// ----------------------------------------------------------------------------
// skt_datapath
// Transaction registers, search window, shift pointer, entry RAM, result
// and output registers of the sorted key table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module skt_datapath #(
  parameter int CAPACITY   = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  skt_pkg::cmd_t                  cmd_i,
  output skt_pkg::stat_t                 st_o,
  input  logic [skt_pkg::ACTION_W-1:0]   action_i,
  input  logic [skt_pkg::KEY_W-1:0]      key_i,
  input  logic [skt_pkg::VALUE_W-1:0]    value_i,
  input  logic [skt_pkg::INDEX_W-1:0]    index_i,
  output logic [skt_pkg::STATUS_W-1:0]   status_o,
  output logic [skt_pkg::KEY_W-1:0]      key_out_o,
  output logic [skt_pkg::VALUE_W-1:0]    value_out_o,
  output logic [skt_pkg::COUNT_W-1:0]    count_o
);

  import skt_pkg::*;

  localparam int AW     = $clog2(CAPACITY);
  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int StoreW = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
  localparam int MemW   = KEY_W + StoreW;
  localparam int CmpW   = (CW > INDEX_W) ? CW : INDEX_W;

  // Captured transaction
  logic [ACTION_W-1:0] action_q;
  logic [KEY_W-1:0]    key_q;
  logic [StoreW-1:0]   val_q;
  logic [INDEX_W-1:0]  index_q;

  // Table state and search control
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid;
  logic [CW-1:0] sp_q, sp_d;
  logic [AW-1:0] wa_q;
  logic          pend_q;

  // Result staging and output registers
  status_e             res_status_q, out_status_q;
  logic [KEY_W-1:0]    res_key_q, out_key_q;
  logic [VALUE_W-1:0]  res_value_q, out_value_q;
  logic [COUNT_W-1:0]  out_count_q;

  // RAM ports
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [MemW-1:0] ram_wdata, ram_rdata;
  logic [KEY_W-1:0]  rd_key;
  logic [StoreW-1:0] rd_val;

  assign rd_key = ram_rdata[StoreW +: KEY_W];
  assign rd_val = ram_rdata[StoreW-1:0];

  // Midpoint of the search window
  assign mid = lo_q + ((hi_q - lo_q) >> 1);

  // Window, count and shift pointer updates
  always_comb begin
    lo_d    = lo_q;
    hi_d    = hi_q;
    sp_d    = sp_q;
    count_d = count_q;
    if (cmd_i.load) begin
      lo_d = '0;
      hi_d = count_q;
      sp_d = count_q;
    end
    if (cmd_i.probe_lt) hi_d = mid_q;
    if (cmd_i.probe_gt) lo_d = mid_q + CW'(1);
    if (cmd_i.shift_rd) sp_d = sp_q - CW'(1);
    if (cmd_i.write_new) count_d = count_q + CW'(1);
  end

  // RAM address and data selection
  always_comb begin
    ram_re    = cmd_i.probe_rd || cmd_i.idx_rd || cmd_i.shift_rd;
    ram_raddr = mid[AW-1:0];
    if (cmd_i.idx_rd) begin
      ram_raddr = AW'(index_q);
    end else if (cmd_i.shift_rd) begin
      ram_raddr = AW'(sp_q - CW'(1));
    end
    ram_we    = cmd_i.write_new || cmd_i.shift_wr;
    ram_waddr = cmd_i.write_new ? lo_q[AW-1:0] : wa_q;
    ram_wdata = cmd_i.write_new ? {key_q, val_q} : ram_rdata;
  end

  skt_ram #(
    .WIDTH (MemW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
      sp_q    <= '0;
      pend_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      sp_q    <= sp_d;
      pend_q  <= cmd_i.shift_rd;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= action_i;
      key_q    <= key_i;
      val_q    <= value_i[StoreW-1:0];
      index_q  <= index_i;
    end
    if (cmd_i.probe_rd) mid_q <= mid;
    if (cmd_i.shift_rd) wa_q <= sp_q[AW-1:0];
  end

  // Result staging
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_key_q   <= key_q;
      res_value_q <= '0;
      unique case (cmd_i.res_sel)
        RES_FOUND_MEM: begin
          res_status_q <= STAT_FOUND;
          res_value_q  <= VALUE_W'(rd_val);
        end
        RES_READ_IDX: begin
          res_status_q <= STAT_FOUND;
          res_key_q    <= rd_key;
          res_value_q  <= VALUE_W'(rd_val);
        end
        RES_NOT_FOUND: res_status_q <= STAT_NOT_FOUND;
        RES_FULL:      res_status_q <= STAT_FULL;
        RES_INSERTED: begin
          res_status_q <= STAT_INSERTED;
          res_value_q  <= VALUE_W'(val_q);
        end
        default:       res_status_q <= STAT_BAD_INDEX;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_key_q    <= res_key_q;
      out_value_q  <= res_value_q;
      out_count_q  <= COUNT_W'(count_q);
    end
  end

  assign status_o    = out_status_q;
  assign key_out_o   = out_key_q;
  assign value_out_o = out_value_q;
  assign count_o     = out_count_q;

  // Status to the controller
  always_comb begin
    st_o            = '0;
    st_o.is_insert  = (action_q == ACT_INSERT);
    st_o.is_lookup  = (action_q == ACT_LOOKUP);
    st_o.is_read    = (action_q == ACT_READ);
    st_o.idx_ok     = CmpW'(index_q) < CmpW'(count_q);
    st_o.open       = lo_q < hi_q;
    st_o.key_eq     = key_q == rd_key;
    st_o.key_lt     = key_q < rd_key;
    st_o.full       = count_q >= CW'(CAPACITY);
    st_o.shift_more = sp_q > lo_q;
    st_o.shift_pend = pend_q;
  end

endmodule

// ----- rtl/sorted_key_table.sv -----
// A transaction is accepted only from idle, so the next one is taken once the last has
// moved its result into the output register. A bad action or index goes straight to
// the result; a read fetches its entry from RAM; a lookup or insert runs
// P <= clog2(CAPACITY+1) probes (RAM read, compare), and a new insert then moves M entries
// up one per cycle and writes the pair. A stalled output register holds the result state.
// Reset clears the entry count and control state; the RAM is not cleared.
// ----------------------------------------------------------------------------
// sorted_key_table
// Map of up to CAPACITY key/value pairs kept in ascending key order, with
// insert, lookup by key and read by sorted position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sorted_key_table #(
  parameter int CAPACITY   = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,  // key[63:0], value[95:64], index[101:96], zero pad
  input  logic [1:0]   s_axis_tuser,  // action[1:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,  // key_out[63:0], value_out[95:64], count[102:96], zero
  output logic [2:0]   m_axis_tuser   // status[2:0]
);

  import skt_pkg::*;

  cmd_t  cmd;
  stat_t st;

  logic [STATUS_W-1:0] status;
  logic [KEY_W-1:0]    key_out;
  logic [VALUE_W-1:0]  value_out;
  logic [COUNT_W-1:0]  count;

  skt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .st_i      (st),
    .cmd_o     (cmd)
  );

  skt_datapath #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .st_o        (st),
    .action_i    (s_axis_tuser),
    .key_i       (s_axis_tdata[63:0]),
    .value_i     (s_axis_tdata[95:64]),
    .index_i     (s_axis_tdata[101:96]),
    .status_o    (status),
    .key_out_o   (key_out),
    .value_out_o (value_out),
    .count_o     (count)
  );

  // Output packing
  assign m_axis_tdata = {1'b0, count, value_out, key_out};
  assign m_axis_tuser = status;

  // A moved entry is written only in the cycle after its read
  `ASSERT_IMPLIES(a_shift_wr_follows_rd, clk_i, rst_ni, cmd.shift_wr, $past(cmd.shift_rd))
  // A pending result is never overwritten
  `ASSERT_IMPLIES(a_no_out_overwrite, clk_i, rst_ni, cmd.out_load,
                  !m_axis_tvalid || m_axis_tready)
  // A new pair is stored only when the table has room
  `ASSERT_IMPLIES(a_write_not_full, clk_i, rst_ni, cmd.write_new, !st.full)
  // Taking a result loads the output register, so valid follows
  `ASSERT_NEXT(a_out_valid_after_load, clk_i, rst_ni, cmd.out_load, m_axis_tvalid)

endmodule
